>>> rtl/core/csm_pkg.sv
// Shared types and constants of the Collatz step counter with memo.
// Holds the fixed field widths and the count saturation helper.
// No dependencies.
package csm_pkg;

	localparam int START_W = 32;
	localparam int COUNT_W = 16;
	localparam int WALK_W  = 64;
	localparam int ACC_W   = COUNT_W + 1;

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	typedef logic [COUNT_W-1:0] count_t;
	typedef logic [ACC_W-1:0]   acc_t;
	typedef logic [START_W-1:0] start_t;
	typedef logic [WALK_W-1:0]  walk_t;

	function automatic count_t sat_count(input acc_t value);
		if (value[ACC_W-1]) begin
			return COUNT_MAX;
		end
		return value[COUNT_W-1:0];
	endfunction

endpackage

>>> rtl/core/collatz_steps_with_memo_unit.sv
// Top level of the Collatz step counter with a memo of small values.
// Depends on csm_pkg for widths, types and count saturation.
// Holds the walk sequencer, the memo memory and the path memory.
//
// The input stream carries one start value per word in s_tdata and the end of a
// range in s_tlast. The output stream returns one word per input word: the step
// count and the best count and start value of the current range in m_tdata, and
// an overflow flag in m_tuser. The record is cleared after a word with s_tlast.
// After reset the block sweeps the memo memory to mark every entry unknown;
// s_tready stays low during the sweep. After an input word is accepted, each
// pass of the walk is a memo read and a step, the pass that lands on a known
// memo entry or on 1 included. The memo write-back then writes the remaining
// count of each small value recorded on the path, read back from the path
// memory, and the result is loaded after it. Overflow and the step limit skip
// the write-back. A start value already in the memo passes through one memo
// read, one step and the write-back; a zero start value goes straight to the
// result load. The registered memo read, one per step, sets the step rate.
// The result waits in an output register, so the next word is accepted while
// the receiver stalls; only a new result waits until the old one is taken.
module collatz_steps_with_memo_unit #(
	parameter int MEMO_DEPTH = 65536,
	parameter int PATH_DEPTH = 2048
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// Bits 31:0 start_value.
	input  logic [csm_pkg::START_W-1:0]   s_tdata,
	input  logic                          s_tlast,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// Bits 15:0 step_count, 31:16 best_count, 63:32 best_start.
	output logic [63:0]                   m_tdata,
	// Bit 0 overflow.
	output logic                          m_tuser
);

	import csm_pkg::*;

	localparam int MW  = (MEMO_DEPTH > 1) ? $clog2(MEMO_DEPTH) : 1;
	localparam int PW  = (PATH_DEPTH > 1) ? $clog2(PATH_DEPTH) : 1;
	localparam int PLW = $clog2(PATH_DEPTH + 1);
	localparam int ME_W = COUNT_W + 1;
	localparam int PE_W = MW + COUNT_W;

	localparam logic [2:0] S_CLR  = 3'd0;
	localparam logic [2:0] S_IDLE = 3'd1;
	localparam logic [2:0] S_LOOK = 3'd2;
	localparam logic [2:0] S_STEP = 3'd3;
	localparam logic [2:0] S_WB   = 3'd4;
	localparam logic [2:0] S_OUT  = 3'd5;

	localparam walk_t      MEMO_LIM  = walk_t'(MEMO_DEPTH);
	localparam logic [PLW-1:0] PATH_LIM = PLW'(PATH_DEPTH);
	localparam logic [MW-1:0]  CLR_LAST = MW'(MEMO_DEPTH - 1);

	logic [2:0]     state_q;
	walk_t          n_q;
	acc_t           steps_q;
	logic [PLW-1:0] plen_q;
	logic [PLW-1:0] rd_idx_q;
	logic           pend_q;
	logic           ovf_q;
	logic           last_q;
	start_t         start_q;
	logic [MW-1:0]  clr_idx_q;
	count_t         rec_count_q;
	start_t         rec_start_q;
	logic           m_tvalid_q;
	logic [63:0]    m_tdata_q;
	logic           m_tuser_q;

	logic [ME_W-1:0] memo [MEMO_DEPTH];
	logic [ME_W-1:0] memo_rd_q;
	logic            memo_we;
	logic [MW-1:0]   memo_wa;
	logic [ME_W-1:0] memo_wd;

	logic [PE_W-1:0] path [PATH_DEPTH];
	logic [PE_W-1:0] path_rd_q;
	logic            path_we;

	logic           is_small;
	logic           hit;
	logic [65:0]    triple;
	acc_t           rem;
	logic           out_free;
	logic           load_out;
	count_t         res_count;
	logic           rec_upd;
	count_t         rec_count_nx;
	start_t         rec_start_nx;

	assign is_small = (n_q < MEMO_LIM);
	assign hit      = is_small && memo_rd_q[COUNT_W];
	assign triple   = {2'b00, n_q} + {1'b0, n_q, 1'b0} + 66'd1;
	assign rem      = steps_q - {1'b0, path_rd_q[COUNT_W-1:0]};
	assign out_free = !m_tvalid_q || m_tready;
	assign load_out = (state_q == S_OUT) && out_free;
	assign path_we  = (state_q == S_STEP) && !hit && is_small && (plen_q < PATH_LIM);

	assign res_count    = ovf_q ? '0 : sat_count(steps_q);
	assign rec_upd      = !ovf_q && (res_count > rec_count_q);
	assign rec_count_nx = rec_upd ? res_count : rec_count_q;
	assign rec_start_nx = rec_upd ? start_q : rec_start_q;

	always_comb begin
		memo_we = 1'b0;
		memo_wa = clr_idx_q;
		memo_wd = '0;
		if (state_q == S_CLR) begin
			memo_we = 1'b1;
		end else if (state_q == S_WB && pend_q) begin
			memo_we = 1'b1;
			memo_wa = path_rd_q[PE_W-1:COUNT_W];
			memo_wd = {1'b1, sat_count(rem)};
		end
	end

	always_ff @(posedge clk) begin
		if (memo_we) begin
			memo[memo_wa] <= memo_wd;
		end
		memo_rd_q <= memo[n_q[MW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (path_we) begin
			path[plen_q[PW-1:0]] <= {n_q[MW-1:0], steps_q[COUNT_W-1:0]};
		end
		path_rd_q <= path[rd_idx_q[PW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			clr_idx_q   <= '0;
			steps_q     <= '0;
			plen_q      <= '0;
			rd_idx_q    <= '0;
			pend_q      <= 1'b0;
			ovf_q       <= 1'b0;
			last_q      <= 1'b0;
			rec_count_q <= '0;
			rec_start_q <= '0;
			m_tvalid_q  <= 1'b0;
		end else begin
			if (load_out) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLR: begin
					clr_idx_q <= clr_idx_q + 1'b1;
					if (clr_idx_q == CLR_LAST) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (s_tvalid) begin
						steps_q  <= '0;
						plen_q   <= '0;
						rd_idx_q <= '0;
						pend_q   <= 1'b0;
						ovf_q    <= 1'b0;
						last_q   <= s_tlast;
						state_q  <= (s_tdata == '0) ? S_OUT : S_LOOK;
					end
				end
				S_LOOK: begin
					state_q <= S_STEP;
				end
				S_STEP: begin
					if (hit) begin
						steps_q <= steps_q + acc_t'(memo_rd_q[COUNT_W-1:0]);
						state_q <= S_WB;
					end else begin
						if (path_we) begin
							plen_q <= plen_q + 1'b1;
						end
						if (n_q == walk_t'(1)) begin
							state_q <= S_WB;
						end else if (steps_q >= acc_t'(COUNT_MAX)) begin
							state_q <= S_OUT;
						end else if (!n_q[0]) begin
							steps_q <= steps_q + 1'b1;
							state_q <= S_LOOK;
						end else if (triple[65:64] != 2'b00) begin
							ovf_q   <= 1'b1;
							state_q <= S_OUT;
						end else begin
							steps_q <= steps_q + 1'b1;
							state_q <= S_LOOK;
						end
					end
				end
				S_WB: begin
					if (rd_idx_q < plen_q) begin
						rd_idx_q <= rd_idx_q + 1'b1;
						pend_q   <= 1'b1;
					end else begin
						pend_q <= 1'b0;
						if (!pend_q) begin
							state_q <= S_OUT;
						end
					end
				end
				S_OUT: begin
					if (out_free) begin
						if (last_q) begin
							rec_count_q <= '0;
							rec_start_q <= '0;
						end else begin
							rec_count_q <= rec_count_nx;
							rec_start_q <= rec_start_nx;
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && s_tvalid) begin
			start_q <= s_tdata;
			n_q     <= walk_t'(s_tdata);
		end else if (state_q == S_STEP && !hit) begin
			if (!n_q[0]) begin
				n_q <= {1'b0, n_q[WALK_W-1:1]};
			end else begin
				n_q <= triple[WALK_W-1:0];
			end
		end
		if (state_q == S_OUT && out_free) begin
			m_tdata_q <= {rec_start_nx, rec_count_nx, res_count};
			m_tuser_q <= ovf_q;
		end
	end

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT && m_tvalid_q && !m_tready) |=> (state_q == S_OUT))
		else $error("Pending result was overwritten.");

	a_ovf_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (m_tdata[15:0] == '0))
		else $error("Overflow result carries a nonzero count.");

	a_accept_next: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (state_q == S_LOOK || state_q == S_OUT))
		else $error("Accepted word did not start a walk.");

	a_path_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(plen_q <= PATH_LIM) && (rd_idx_q <= plen_q))
		else $error("Path store index out of range.");

endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps
// Testbench for collatz_steps_with_memo_unit: streams start values, predicts each result
// with an in-bench memo walk and checks every output word. Depends on csm_pkg and the RTL.
module tb;
	import csm_pkg::*;

	localparam int MEMO_N = 65536;
	localparam int PATH_N = 2048;
	localparam int IDLE_LIMIT = 1000000;
	localparam walk_t ODD_LIMIT = 64'hFFFF_FFFF_FFFF_FFFE / 3;

	typedef struct packed {
		count_t step;
		count_t best;
		start_t best_start;
		logic   ovf;
	} result_t;

	logic                clk;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	logic [START_W-1:0]  s_tdata;
	logic                s_tlast;
	logic                m_tvalid;
	logic                m_tready;
	logic [63:0]         m_tdata;
	logic                m_tuser;

	count_t  memo_steps [MEMO_N];
	bit      memo_valid [MEMO_N];
	start_t  walk_vals [PATH_N];
	int unsigned walk_pos [PATH_N];
	count_t  best_steps = '0;
	start_t  best_from = '0;
	result_t pending_results[$];
	int      mismatches = 0;
	int      results_seen = 0;
	int      burst_left = 4;

	collatz_steps_with_memo_unit #(
		.MEMO_DEPTH(MEMO_N),
		.PATH_DEPTH(PATH_N)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic result_t predict_steps(input start_t start, input logic last);
		walk_t       n;
		int unsigned steps;
		int unsigned plen;
		int unsigned rem;
		bit          ovf;
		bit          capped;
		bit          done;
		count_t      cnt;
		result_t     r;
		n = walk_t'(start);
		steps = 0;
		plen = 0;
		ovf = 1'b0;
		capped = 1'b0;
		done = 1'b0;
		cnt = '0;
		if (start != 0) begin
			while (!done) begin
				if (n < walk_t'(MEMO_N) && memo_valid[n[15:0]]) begin
					steps += memo_steps[n[15:0]];
					done = 1'b1;
				end else begin
					if (n < walk_t'(MEMO_N) && plen < PATH_N) begin
						walk_vals[plen] = start_t'(n);
						walk_pos[plen] = steps;
						plen++;
					end
					if (n == 1) begin
						done = 1'b1;
					end else if (steps >= COUNT_MAX) begin
						capped = 1'b1;
						done = 1'b1;
					end else if (!n[0]) begin
						n = n >> 1;
						steps++;
					end else if (n > ODD_LIMIT) begin
						ovf = 1'b1;
						done = 1'b1;
					end else begin
						n = 3 * n + 1;
						steps++;
					end
				end
			end
			if (!ovf && !capped) begin
				for (int i = 0; i < plen; i++) begin
					rem = steps - walk_pos[i];
					if (rem > COUNT_MAX)
						rem = 32'(COUNT_MAX);
					memo_steps[walk_vals[i][15:0]] = count_t'(rem);
					memo_valid[walk_vals[i][15:0]] = 1'b1;
				end
			end
			if (!ovf)
				cnt = (steps > COUNT_MAX) ? COUNT_MAX : count_t'(steps);
		end
		if (!ovf && cnt > best_steps) begin
			best_steps = cnt;
			best_from = start;
		end
		r.step = cnt;
		r.best = best_steps;
		r.best_start = best_from;
		r.ovf = ovf;
		if (last) begin
			best_steps = '0;
			best_from = '0;
		end
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		mismatches++;
		if (mismatches <= 40)
			$display("MISMATCH word %0d %s: got %0h, expected %0h", results_seen, what, got, want);
	endtask

	task automatic hold_off(input int cycles);
		@(negedge clk);
		s_tvalid = 1'b0;
		s_tdata = $urandom();
		s_tlast = 1'($urandom_range(0, 1));
		repeat (cycles - 1) @(negedge clk);
	endtask

	task automatic push_word(input start_t start, input logic last);
		@(negedge clk);
		s_tvalid = 1'b1;
		s_tdata = start;
		s_tlast = last;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		pending_results = {pending_results, predict_steps(start, last)};
		burst_left--;
		if (burst_left <= 0) begin
			hold_off($urandom_range(1, 12));
			burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 10);
		end
	endtask

	task automatic wait_drained();
		hold_off(1);
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	function automatic start_t pick_start();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return $urandom();
		if (r < 80)
			return $urandom_range(1, 65535);
		if (r < 90)
			return $urandom_range(1, 1 << 20);
		if (r < 95)
			return 32'h1 << $urandom_range(0, 31);
		case ($urandom_range(0, 4))
			0: return 32'h0;
			1: return 32'h1;
			2: return 32'hFFFF_FFFF;
			3: return 32'h0000_FFFF;
			default: return 32'h0001_0000;
		endcase
	endfunction

	// Extremes, zero, ties, memo hits on the start value and back-to-back range ends.
	task automatic test_directed();
		push_word(32'd1, 1'b0);
		push_word(32'd2, 1'b0);
		push_word(32'd3, 1'b0);
		push_word(32'd0, 1'b0);
		push_word(32'd27, 1'b0);
		push_word(32'd27, 1'b0);
		push_word(32'd12, 1'b0);
		push_word(32'd13, 1'b0);
		push_word(32'hFFFF_FFFF, 1'b1);
		push_word(32'd0, 1'b1);
		push_word(32'h8000_0000, 1'b0);
		push_word(32'd65535, 1'b0);
		push_word(32'd65536, 1'b0);
		push_word(32'd65537, 1'b0);
		push_word(32'h7FFF_FFFF, 1'b0);
		push_word(32'hAAAA_AAAA, 1'b0);
		push_word(32'h5555_5555, 1'b0);
		push_word(32'd6171, 1'b0);
		push_word(32'd1, 1'b1);
		push_word(32'd77031, 1'b0);
		push_word(32'd837799, 1'b0);
		push_word(32'd63728127, 1'b0);
		push_word(32'd670617279, 1'b0);
		push_word(32'hFFFF_FFFE, 1'b1);
	endtask

	// Small start values in short ranges so that most walks end on a memo entry.
	task automatic test_memo_reuse(input int count);
		int len;
		while (count > 0) begin
			len = $urandom_range(1, 20);
			for (int i = 0; i < len; i++)
				push_word($urandom_range(1, 4095), i == len - 1);
			count -= len;
		end
	endtask

	// The sender stops until every outstanding word has come back, a few times over.
	task automatic test_drain_pause();
		for (int k = 0; k < 4; k++) begin
			for (int i = 0; i < 6; i++)
				push_word(pick_start(), i == 5);
			wait_drained();
		end
	endtask

	// Ranges of random length; some ranges carry stray range ends in the middle.
	task automatic test_random_ranges(input int count);
		int  len;
		bit  broken;
		int  since_drain;
		since_drain = 0;
		while (count > 0) begin
			len = $urandom_range(1, 40);
			broken = ($urandom_range(0, 9) == 0);
			for (int i = 0; i < len; i++)
				push_word(pick_start(), 1'(broken ? $urandom_range(0, 1) : (i == len - 1)));
			count -= len;
			since_drain += len;
			if (since_drain > 300) begin
				wait_drained();
				since_drain = 0;
			end
		end
	endtask

	initial begin : receiver_pattern
		int unsigned cyc;
		cyc = 0;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			cyc++;
			case (cyc[9:8])
				2'd0: m_tready = 1'b1;
				2'd1: m_tready = ($urandom_range(0, 3) != 0);
				2'd2: m_tready = ($urandom_range(0, 3) == 0);
				default: m_tready = (cyc[3:0] < 4'd3);
			endcase
		end
	end

	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected word", m_tdata, 64'h0);
			end else begin
				want = pending_results.pop_front();
				if (m_tdata[15:0] !== want.step)
					report_mismatch("step_count", 64'(m_tdata[15:0]), 64'(want.step));
				if (m_tdata[31:16] !== want.best)
					report_mismatch("best_count", 64'(m_tdata[31:16]), 64'(want.best));
				if (m_tdata[63:32] !== want.best_start)
					report_mismatch("best_start", 64'(m_tdata[63:32]),
						64'(want.best_start));
				if (m_tuser !== want.ovf)
					report_mismatch("overflow", 64'(m_tuser), 64'(want.ovf));
			end
		end
	end

	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("collatz_steps_with_memo_unit verification failed");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tlast = 1'b0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_memo_reuse(300);
		test_drain_pause();
		test_random_ranges(1260);
		wait_drained();
		repeat (100) @(posedge clk);
		if (mismatches == 0) begin
			$display("collatz_steps_with_memo_unit verification clean");
		end else begin
			$display("collatz_steps_with_memo_unit verification failed");
		end
		$finish;
	end

endmodule

>>> collatz_steps_with_memo_unit.f
rtl/core/csm_pkg.sv
rtl/core/collatz_steps_with_memo_unit.sv
verif/tb.sv
